// ===== src/ffba_pkg.sv =====
`default_nettype none

package ffba_pkg;

    // Reset value of the heap limit register
    localparam logic [63:0] LIMIT_RESET = 64'hFFFF_FFFF_FFFF_F000;

    // Register indexes, selected by paddr[3]
    localparam logic REG_HEAP_BASE  = 1'b0;
    localparam logic REG_HEAP_LIMIT = 1'b1;

    // Request kinds
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_SPACE   = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;
    localparam logic [1:0] ST_UNKNOWN    = 2'd3;

    // Result and table-update operations issued by the controller
    typedef logic [2:0] t_res_op;
    localparam t_res_op RES_NONE      = 3'd0;
    localparam t_res_op RES_NULL_FREE = 3'd1;
    localparam t_res_op RES_REUSE     = 3'd2;
    localparam t_res_op RES_FREED     = 3'd3;
    localparam t_res_op RES_UNKNOWN   = 3'd4;
    localparam t_res_op RES_NO_SPACE  = 3'd5;
    localparam t_res_op RES_FULL      = 3'd6;
    localparam t_res_op RES_BUMP      = 3'd7;

    typedef struct packed {
        logic    start;     // capture the request, rewind the scan
        logic    scan;      // issue the next table read
        logic    bump_sum;  // form bump pointer plus total
        logic    out_load;  // move the result into the output register
        t_res_op res;       // set result and update the table
    } t_dp_cmd;

    typedef struct packed {
        logic in_alloc;   // request at the input is an allocate
        logic in_null;    // free address at the input is null
        logic is_alloc;   // captured request is an allocate
        logic hit;        // entry read last cycle matches
        logic exhausted;  // no entry left to read or compare
        logic fits;       // bump end lies strictly below the limit
        logic full;       // table holds its maximum of blocks
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== src/first_fit_block_allocator.sv =====
// First-fit heap allocator over a table of up to MAX_BLOCKS blocks.
// Input channel (i_valid/o_ready) takes one word: i_action selects allocate
// or free, with i_request_size or i_free_address. Output channel
// (o_valid/i_ready) returns one word per input: o_address, o_status, o_reused.
// Allocate scans the table newest first for a free block big enough, else
// carves a new block at the bump pointer. Free marks the newest block whose
// user address matches; a null free completes at once.
// Timing: the scan reads one table entry per cycle from a single-port table
// memory; a bump allocation then forms the block end and checks it against
// the limit and the table fill. One item is worked on at a time; the next
// word is taken the cycle after the result is loaded.
// The output register holds a finished word while the receiver stalls; the
// next word is accepted and scanned meanwhile, and waits for the register.
// Reset (synchronous, active low) empties the table, sets heap_base and the
// bump pointer to 0 and heap_limit to 0xFFFFFFFFFFFFF000. No clearing pass.
// Registers via the APB-style port: heap_base at 0x0 (a write also reloads
// the bump pointer), heap_limit at 0x8. Write them only while idle.
`default_nettype none

module first_fit_block_allocator #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request words
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_action,
    input  wire logic [31:0] i_request_size,
    input  wire logic [63:0] i_free_address,
    // result words
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_address,
    output logic [1:0]       o_status,
    output logic             o_reused,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    ffba_pkg::t_dp_cmd  w_cmd;
    ffba_pkg::t_dp_stat w_stat;

    logic        w_wr;
    logic        w_base_we;
    logic        w_limit_we;
    logic [63:0] w_heap_base;
    logic [63:0] w_heap_limit;

    // Decode on paddr[3] alone; the low address bits are ignored.
    assign pready     = 1'b1;
    assign w_wr       = psel && penable && pwrite;
    assign w_base_we  = w_wr && (paddr[3] == ffba_pkg::REG_HEAP_BASE);
    assign w_limit_we = w_wr && (paddr[3] == ffba_pkg::REG_HEAP_LIMIT);
    assign prdata     = (paddr[3] == ffba_pkg::REG_HEAP_LIMIT) ? w_heap_limit : w_heap_base;

    // Sequence the scan, bump check and result hand-off.
    ffba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_ready (o_ready),
        .o_valid (o_valid)
    );

    // Hold the block table, bump pointer, registers and result words.
    ffba_dp #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_action       (i_action),
        .i_request_size (i_request_size),
        .i_free_address (i_free_address),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_base_we      (w_base_we),
        .i_limit_we     (w_limit_we),
        .i_wdata        (pwdata),
        .o_heap_base    (w_heap_base),
        .o_heap_limit   (w_heap_limit),
        .o_address      (o_address),
        .o_status       (o_status),
        .o_reused       (o_reused)
    );

endmodule

`default_nettype wire

// ===== src/ffba_ctrl.sv =====
`default_nettype none

module ffba_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              i_ready,
    input  wire ffba_pkg::t_dp_stat i_stat,
    output ffba_pkg::t_dp_cmd      o_cmd,
    output logic                   o_ready,
    output logic                   o_valid
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_BUMP_ADD = 3'd2;
    localparam logic [2:0] S_BUMP_CHK = 3'd3;
    localparam logic [2:0] S_FIN      = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_vld;
    logic       n_out_vld;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    if (!i_stat.in_alloc && i_stat.in_null) begin
                        o_cmd.res = ffba_pkg::RES_NULL_FREE;
                        n_state   = S_FIN;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                priority if (i_stat.hit) begin
                    o_cmd.res = i_stat.is_alloc ? ffba_pkg::RES_REUSE : ffba_pkg::RES_FREED;
                    n_state   = S_FIN;
                end else if (i_stat.exhausted) begin
                    if (i_stat.is_alloc) begin
                        n_state = S_BUMP_ADD;
                    end else begin
                        o_cmd.res = ffba_pkg::RES_UNKNOWN;
                        n_state   = S_FIN;
                    end
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_BUMP_ADD: begin
                o_cmd.bump_sum = 1'b1;
                n_state        = S_BUMP_CHK;
            end
            S_BUMP_CHK: begin
                priority if (!i_stat.fits) begin
                    o_cmd.res = ffba_pkg::RES_NO_SPACE;
                end else if (i_stat.full) begin
                    o_cmd.res = ffba_pkg::RES_FULL;
                end else begin
                    o_cmd.res = ffba_pkg::RES_BUMP;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                // wait for the output register to drain
                if (!r_out_vld || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_vld = o_cmd.out_load ? 1'b1 : (i_ready ? 1'b0 : r_out_vld);
    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state != S_IDLE))
        else $error("accepted word did not leave idle");

endmodule

`default_nettype wire

// ===== src/ffba_dp.sv =====
`default_nettype none

module ffba_dp #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_action,
    input  wire logic [31:0]        i_request_size,
    input  wire logic [63:0]        i_free_address,
    input  wire ffba_pkg::t_dp_cmd  i_cmd,
    output ffba_pkg::t_dp_stat      o_stat,
    input  wire logic               i_base_we,
    input  wire logic               i_limit_we,
    input  wire logic [63:0]        i_wdata,
    output logic [63:0]             o_heap_base,
    output logic [63:0]             o_heap_limit,
    output logic [63:0]             o_address,
    output logic [1:0]              o_status,
    output logic                    o_reused
);

    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCKS);
    localparam logic [63:0]   HDR64   = 64'(HEADER_BYTES);
    localparam logic [32:0]   HDR33   = 33'(HEADER_BYTES);

    // block table
    logic [63:0] m_start [MAX_BLOCKS];
    logic [32:0] m_total [MAX_BLOCKS];
    logic        m_free  [MAX_BLOCKS];

    logic [63:0]   r_base;
    logic [63:0]   r_limit;
    logic [63:0]   r_bump;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_left;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    logic          r_is_alloc;
    logic [32:0]   r_need;
    logic [63:0]   r_target;
    logic [64:0]   r_end;
    logic [63:0]   r_q_start;
    logic [32:0]   r_q_total;
    logic          r_q_free;
    logic [63:0]   r_res_addr;
    logic [1:0]    r_res_status;
    logic          r_res_reused;
    logic [63:0]   r_out_addr;
    logic [1:0]    r_out_status;
    logic          r_out_reused;

    logic [CW-1:0] w_left_m1;
    logic [IW-1:0] w_rd_addr;
    logic          w_issue;
    logic          w_match;
    logic          w_wr_bump;
    logic [IW-1:0] w_bump_idx;
    logic          w_wf_en;
    logic [IW-1:0] w_wf_idx;
    logic          w_wf_val;

    assign w_left_m1  = r_left - CW'(1);
    assign w_rd_addr  = w_left_m1[IW-1:0];
    assign w_issue    = i_cmd.scan && (r_left != '0);
    assign w_wr_bump  = (i_cmd.res == ffba_pkg::RES_BUMP);
    assign w_bump_idx = r_count[IW-1:0];

    assign w_match = r_is_alloc ? (r_q_free && (r_q_total >= r_need))
                                : (r_q_start == r_target);

    always_comb begin
        w_wf_en  = 1'b0;
        w_wf_idx = r_rd_idx;
        w_wf_val = 1'b0;
        priority if (w_wr_bump) begin
            w_wf_en  = 1'b1;
            w_wf_idx = w_bump_idx;
        end else if (i_cmd.res == ffba_pkg::RES_REUSE) begin
            w_wf_en = 1'b1;
        end else if (i_cmd.res == ffba_pkg::RES_FREED) begin
            w_wf_en  = 1'b1;
            w_wf_val = 1'b1;
        end else begin
            w_wf_en = 1'b0;
        end
    end

    always_comb begin
        o_stat.in_alloc  = (i_action == ffba_pkg::ACT_ALLOC);
        o_stat.in_null   = (i_free_address == 64'd0);
        o_stat.is_alloc  = r_is_alloc;
        o_stat.hit       = r_rd_vld && w_match;
        o_stat.exhausted = (r_left == '0) && !r_rd_vld;
        o_stat.fits      = !r_end[64] && (r_end[63:0] < r_limit);
        o_stat.full      = (r_count >= MAX_CNT);
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_bump) begin
            m_start[w_bump_idx] <= r_bump;
        end
        if (w_issue) begin
            r_q_start <= m_start[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_bump) begin
            m_total[w_bump_idx] <= r_need;
        end
        if (w_issue) begin
            r_q_total <= m_total[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wf_en) begin
            m_free[w_wf_idx] <= w_wf_val;
        end
        if (w_issue) begin
            r_q_free <= m_free[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= 64'd0;
            r_limit  <= ffba_pkg::LIMIT_RESET;
            r_bump   <= 64'd0;
            r_count  <= '0;
            r_left   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_base_we) begin
                r_base <= i_wdata;
                r_bump <= i_wdata;
            end
            if (i_limit_we) begin
                r_limit <= i_wdata;
            end
            if (i_cmd.start) begin
                r_left   <= r_count;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                if (r_left != '0) begin
                    r_left <= w_left_m1;
                end
                r_rd_vld <= (r_left != '0);
            end
            if (w_wr_bump) begin
                r_count <= r_count + CW'(1);
                r_bump  <= r_end[63:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_is_alloc <= (i_action == ffba_pkg::ACT_ALLOC);
            r_need     <= {1'b0, i_request_size} + HDR33;
            r_target   <= i_free_address - HDR64;
        end
        if (w_issue) begin
            r_rd_idx <= w_rd_addr;
        end
        if (i_cmd.bump_sum) begin
            r_end <= {1'b0, r_bump} + 65'(r_need);
        end
        unique case (i_cmd.res)
            ffba_pkg::RES_NONE: begin
                r_res_addr <= r_res_addr;
            end
            ffba_pkg::RES_NULL_FREE, ffba_pkg::RES_FREED: begin
                r_res_addr   <= 64'd0;
                r_res_status <= ffba_pkg::ST_OK;
                r_res_reused <= 1'b0;
            end
            ffba_pkg::RES_REUSE: begin
                r_res_addr   <= r_q_start + HDR64;
                r_res_status <= ffba_pkg::ST_OK;
                r_res_reused <= 1'b1;
            end
            ffba_pkg::RES_UNKNOWN: begin
                r_res_addr   <= 64'd0;
                r_res_status <= ffba_pkg::ST_UNKNOWN;
                r_res_reused <= 1'b0;
            end
            ffba_pkg::RES_NO_SPACE: begin
                r_res_addr   <= 64'd0;
                r_res_status <= ffba_pkg::ST_NO_SPACE;
                r_res_reused <= 1'b0;
            end
            ffba_pkg::RES_FULL: begin
                r_res_addr   <= 64'd0;
                r_res_status <= ffba_pkg::ST_TABLE_FULL;
                r_res_reused <= 1'b0;
            end
            ffba_pkg::RES_BUMP: begin
                r_res_addr   <= r_bump + HDR64;
                r_res_status <= ffba_pkg::ST_OK;
                r_res_reused <= 1'b0;
            end
            default: begin
                r_res_addr <= r_res_addr;
            end
        endcase
        if (i_cmd.out_load) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
            r_out_reused <= r_res_reused;
        end
    end

    assign o_heap_base  = r_base;
    assign o_heap_limit = r_limit;
    assign o_address    = r_out_addr;
    assign o_status     = r_out_status;
    assign o_reused     = r_out_reused;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("block count above table depth");

    a_read_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (CW'(r_rd_idx) < r_count))
        else $error("scan read an entry beyond the table fill");

    a_count_on_bump_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.res != ffba_pkg::RES_BUMP) |=> $stable(r_count))
        else $error("block count moved without a bump allocation");

endmodule

`default_nettype wire

// ===== bench/first_fit_block_allocator_tb.sv =====
module first_fit_block_allocator_tb;

    localparam int MAX_BLOCKS       = 64;
    localparam int HEADER_BYTES     = 24;
    // Give the longest item room to finish, with slack.
    localparam int SETTLE_CYCLES    = MAX_BLOCKS + 8;
    localparam int RANDOM_PER_PHASE = 160;
    // Watchdog cap on the whole run, well above a nominal run.
    localparam int CYCLE_LIMIT      = 600000;

    typedef struct packed {
        logic        action;
        logic [31:0] req_size;
        logic [63:0] free_addr;
    } t_req_word;

    typedef struct packed {
        logic [63:0] address;
        logic [1:0]  status;
        logic        reused;
    } t_alloc_result;

    // Block-level inputs start at known values.
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        i_action       = ffba_pkg::ACT_ALLOC;
    logic [31:0] i_request_size = '0;
    logic [63:0] i_free_address = '0;
    logic        i_ready        = 1'b0;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [3:0]  paddr          = '0;
    logic [63:0] pwdata         = '0;

    logic        o_ready;
    logic        o_valid;
    logic [63:0] o_address;
    logic [1:0]  o_status;
    logic        o_reused;
    logic [63:0] prdata;
    logic        pready;

    // Words waiting to be sent, and results owed by the block, oldest first.
    t_req_word     pending_reqs[$];
    t_alloc_result awaited_results[$];
    t_req_word     cur_req;

    int unsigned send_gap_pct = 0;
    int unsigned stall_pct    = 0;
    int unsigned fail_count   = 0;
    int unsigned cycle_count  = 0;

    // Shadow of the allocator: registers, bump pointer and block table.
    logic [63:0] heap_limit_cfg = ffba_pkg::LIMIT_RESET;
    logic [63:0] bump_ptr       = '0;
    logic [63:0] blk_start[MAX_BLOCKS];
    logic [32:0] blk_total[MAX_BLOCKS];
    logic        blk_free[MAX_BLOCKS];
    int          blocks_used    = 0;

    first_fit_block_allocator #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .HEADER_BYTES(HEADER_BYTES)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_request_size(i_request_size),
        .i_free_address(i_free_address),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_address     (o_address),
        .o_status      (o_status),
        .o_reused      (o_reused),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 i_clk = ~i_clk;

    // Work out the result of one accepted word and advance the shadow table.
    function automatic t_alloc_result allocate_or_free(t_req_word w);
        t_alloc_result r;
        logic [32:0]   need;
        logic [64:0]   bump_end;
        int            i;
        bit            found;
        r     = '0;
        found = 1'b0;
        if (w.action == ffba_pkg::ACT_ALLOC) begin
            need = {1'b0, w.req_size} + 33'(HEADER_BYTES);
            // First fit, newest entry first; a hit is handed back whole.
            for (i = blocks_used - 1; i >= 0 && !found; i--) begin
                if (blk_free[i] && blk_total[i] >= need) begin
                    found       = 1'b1;
                    blk_free[i] = 1'b0;
                    r.address   = blk_start[i] + 64'(HEADER_BYTES);
                    r.reused    = 1'b1;
                end
            end
            if (!found) begin
                // Space is checked before the table: both short gives no-space.
                bump_end = {1'b0, bump_ptr} + {32'b0, need};
                if (bump_end[64] || bump_end[63:0] >= heap_limit_cfg) begin
                    r.status = ffba_pkg::ST_NO_SPACE;
                end else if (blocks_used >= MAX_BLOCKS) begin
                    r.status = ffba_pkg::ST_TABLE_FULL;
                end else begin
                    blk_start[blocks_used] = bump_ptr;
                    blk_total[blocks_used] = need;
                    blk_free[blocks_used]  = 1'b0;
                    blocks_used++;
                    r.address = bump_ptr + 64'(HEADER_BYTES);
                    bump_ptr  = bump_end[63:0];
                end
            end
        end else if (w.free_addr != '0) begin
            // Newest matching entry wins, even if it is already free.
            for (i = blocks_used - 1; i >= 0 && !found; i--) begin
                if (blk_start[i] + 64'(HEADER_BYTES) == w.free_addr) begin
                    found       = 1'b1;
                    blk_free[i] = 1'b1;
                end
            end
            if (!found) r.status = ffba_pkg::ST_UNKNOWN;
        end
        return r;
    endfunction

    // Sender: hold the word until accepted, then load the next one or idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                awaited_results.push_back(allocate_or_free(cur_req));
            end
            if (!i_valid || o_ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
                    cur_req = pending_reqs.pop_front();
                    i_valid        <= 1'b1;
                    i_action       <= cur_req.action;
                    i_request_size <= cur_req.req_size;
                    i_free_address <= cur_req.free_addr;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall at random, one decision per cycle.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Check every accepted result word against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_results.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected result word: addr %h status %0d reused %0d",
                             o_address, o_status, o_reused);
                fail_count++;
            end else begin
                t_alloc_result want;
                want = awaited_results.pop_front();
                if (o_address !== want.address || o_status !== want.status ||
                    o_reused !== want.reused) begin
                    if (fail_count < 10)
                        $display("mismatch: want %h/%0d/%0d got %h/%0d/%0d",
                                 want.address, want.status, want.reused,
                                 o_address, o_status, o_reused);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Keep at most two words queued so free addresses track the shadow table.
    task automatic push_word(t_req_word w);
        while (pending_reqs.size() >= 2) @(negedge i_clk);
        pending_reqs.push_back(w);
    endtask

    // Unused field gets random garbage; the block must ignore it.
    task automatic queue_alloc(logic [31:0] sz);
        t_req_word w;
        w.action    = ffba_pkg::ACT_ALLOC;
        w.req_size  = sz;
        w.free_addr = {$urandom, $urandom};
        push_word(w);
    endtask

    task automatic queue_free(logic [63:0] addr);
        t_req_word w;
        w.action    = ffba_pkg::ACT_FREE;
        w.req_size  = $urandom;
        w.free_addr = addr;
        push_word(w);
    endtask

    // Mostly well-formed traffic: small sizes so freed blocks get reused, and
    // frees aimed at live table entries; the rest is null and stray addresses.
    task automatic queue_random_word();
        t_req_word   w;
        int unsigned roll;
        w.req_size  = $urandom;
        w.free_addr = {$urandom, $urandom};
        roll = $urandom_range(99);
        if (roll < 58) begin
            w.action = ffba_pkg::ACT_ALLOC;
            roll = $urandom_range(99);
            if (roll < 70)      w.req_size = $urandom_range(200);
            else if (roll < 85) w.req_size = $urandom_range(4095);
        end else begin
            w.action = ffba_pkg::ACT_FREE;
            roll = $urandom_range(99);
            if (roll < 8) begin
                w.free_addr = '0;
            end else if (roll < 83 && blocks_used > 0) begin
                w.free_addr = blk_start[$urandom_range(blocks_used - 1)]
                              + 64'(HEADER_BYTES);
            end else if (roll < 92 && blocks_used > 0) begin
                // Near miss on a real block address.
                w.free_addr = blk_start[$urandom_range(blocks_used - 1)]
                              + 64'(HEADER_BYTES) + 64'($urandom_range(1, 7));
            end
        end
        push_word(w);
    endtask

    // Register write: setup cycle, then access cycle; pready is always high.
    task automatic write_reg(logic reg_sel, logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // Writing the base also reloads the bump pointer; the table stays.
        if (reg_sel == ffba_pkg::REG_HEAP_BASE) bump_ptr = value;
        else heap_limit_cfg = value;
    endtask

    task automatic set_heap(logic [63:0] base, logic [63:0] limit);
        write_reg(ffba_pkg::REG_HEAP_BASE, base);
        write_reg(ffba_pkg::REG_HEAP_LIMIT, limit);
    endtask

    // Pause the sender until every owed result has come back, then let the
    // block settle so it is idle for a register write.
    task automatic drain();
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_valid || awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int ph;
        int n;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset config: base 0, default limit. Walk null free, unknown free,
        // size extremes, double free, exact-fit reuse and newest-first pick.
        queue_free(64'd0);
        queue_free(64'hFFFF_FFFF_FFFF_FFFF);
        queue_alloc(32'd0);                   // block at 0, user address 24
        queue_alloc(32'hFFFF_FFFF);           // block at 24, user address 48
        queue_alloc(32'd100);                 // user address 0x1_0000_0047
        queue_free(64'd24);
        queue_free(64'd24);                   // already free: still ok
        queue_alloc(32'd0);                   // exact fit, reuse
        queue_free(64'd48);
        queue_alloc(32'd50);                  // reuse the huge block
        queue_free(64'h1_0000_0047);
        queue_free(64'd48);
        queue_alloc(32'd10);                  // both fit; newest must win
        queue_free(64'd25);                   // off by one: unknown
        drain();

        // Tight window: take back the huge block, then bump right up to the
        // limit and one past it.
        set_heap(64'h1000, 64'h1094);
        queue_alloc(32'hFFFF_FFFF);
        queue_alloc(32'd99);
        queue_alloc(32'd0);                   // ends one below the limit
        queue_alloc(32'd0);                   // past the limit: no space
        drain();

        // Top of the address space: second bump would wrap past 2^64.
        set_heap(64'hFFFF_FFFF_FFFF_FFE0, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_alloc(32'd0);
        queue_alloc(32'd0);
        queue_free(64'hFFFF_FFFF_FFFF_FFF8);
        queue_alloc(32'd0);
        drain();

        // Zero limit: bumps fail, reuse still works.
        set_heap(64'd0, 64'd0);
        queue_alloc(32'd7);
        queue_free(64'd24);
        queue_alloc(32'd0);
        drain();

        // Random phases, each with its own heap window and idling mix.
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_heap({32'b0, $urandom} & ~64'hF, 64'hFFFF_FFFF_FFFF_FFFF);
                1: set_heap({16'b0, 16'($urandom), $urandom}, ffba_pkg::LIMIT_RESET);
                2: set_heap(64'd0, 64'h4000);
                default: set_heap({$urandom, $urandom}, {$urandom, $urandom});
            endcase
            case (ph)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 49; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 49; end
                default: begin send_gap_pct = 32; stall_pct = 32; end
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++) queue_random_word();
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && awaited_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
